/* rtl/depthwise_conv2d_stream_defines.svh */
// Assertion macros used by the depthwise convolution top level.
`ifndef DEPTHWISE_CONV2D_STREAM_DEFINES_SVH
`define DEPTHWISE_CONV2D_STREAM_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define DWC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define DWC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DWC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DWC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/dwc_pkg.sv */
// Shared types, constants and helper functions of the depthwise convolution block.
`default_nettype none
package dwc_pkg;

   localparam int KERNEL_MAX_DEF  = 7;
   localparam int WIDTH_MAX_DEF   = 256;
   localparam int HEIGHT_MAX_DEF  = 256;
   localparam int CHANNEL_MAX_DEF = 1024;

   localparam int SAMPLE_W   = 16;
   localparam int CSR_DATA_W = 11;
   localparam int DIM_W      = 13;   // geometry math width, covers 4096
   localparam int KDIM_W     = 4;    // clamped kernel size, covers 11
   localparam int ACC_W      = 40;   // exact sum of products plus bias
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;

   typedef enum logic [1:0] {
      FUNC_PIXEL  = 2'd0,
      FUNC_WEIGHT = 2'd1,
      FUNC_BIAS   = 2'd2
   } dwc_func_type;

   typedef enum logic [2:0] {
      REG_RELU     = 3'd0,
      REG_KERNEL_W = 3'd1,
      REG_KERNEL_H = 3'd2,
      REG_STRIDE_W = 3'd3,
      REG_STRIDE_H = 3'd4,
      REG_IMAGE_W  = 3'd5,
      REG_IMAGE_H  = 3'd6,
      REG_CHANNELS = 3'd7
   } dwc_reg_type;

   typedef struct packed {
      logic        relu_enable;
      logic [2:0]  kernel_w;
      logic [2:0]  kernel_h;
      logic [2:0]  stride_w;
      logic [2:0]  stride_h;
      logic [8:0]  image_width;
      logic [8:0]  image_height;
      logic [10:0] channel_count;
   } dwc_cfg_type;

   typedef struct packed {
      logic res;
      logic last_ch;
      logic last_fr;
   } dwc_tag_type;

   // zero acts as one, anything above hi acts as hi
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

   // x mod k for k in 1..7, x below 4096; reciprocal multiply is exact there
   function automatic logic [2:0] mod_small(input logic [DIM_W-1:0] x,
                                            input logic [2:0] k);
      logic [15:0] m;
      logic [28:0] p;
      logic [DIM_W-1:0] q;
      logic [15:0] rr;
      logic [2:0] r;
      case (k)
         3'd3: m = 16'd21846;
         3'd5: m = 16'd13108;
         3'd6: m = 16'd10923;
         3'd7: m = 16'd9363;
         default: m = 16'd0;
      endcase
      p = 29'(x) * 29'(m);
      q = p[28:16];
      rr = 16'(x) - 16'(q) * 16'(k);
      case (k)
         3'd2: r = {2'b00, x[0]};
         3'd4: r = {1'b0, x[1:0]};
         3'd3, 3'd5, 3'd6, 3'd7: r = rr[2:0];
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/dwc_ram.sv */
// Generic single-clock RAM, one write port, one registered read port.
`default_nettype none
module dwc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // read returns old data on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/dwc_front.sv */
// Raster counters, line store read-modify-write, window registers, weight alignment and result tags.
`default_nettype none
module dwc_front import dwc_pkg::*; #(
   parameter int KERNEL_MAX  = KERNEL_MAX_DEF,
   parameter int WIDTH_MAX   = WIDTH_MAX_DEF,
   parameter int HEIGHT_MAX  = HEIGHT_MAX_DEF,
   parameter int CHANNEL_MAX = CHANNEL_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dwc_cfg_type cfg,
   input  wire logic        in_valid,
   input  wire dwc_func_type in_func,
   input  wire logic [SAMPLE_W-1:0] in_sample,
   input  wire logic [5:0]  in_weight_index,
   output logic [KERNEL_MAX*KERNEL_MAX-1:0][SAMPLE_W-1:0] win_o,
   output logic [KERNEL_MAX*KERNEL_MAX-1:0][SAMPLE_W-1:0] wsel_ff,
   output logic [SAMPLE_W-1:0] bias_s2_ff,
   output dwc_tag_type      tag_s2_ff,
   output logic [1:0]       occ
);
   localparam int N      = KERNEL_MAX * KERNEL_MAX;
   localparam int LINES  = (KERNEL_MAX > 1) ? KERNEL_MAX - 1 : 1;
   localparam int SLOT_W = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int CW     = $clog2(WIDTH_MAX);
   localparam int RW     = $clog2(HEIGHT_MAX);
   localparam int CHW    = (CHANNEL_MAX > 1) ? $clog2(CHANNEL_MAX) : 1;
   localparam int WI_W   = (N > 1) ? $clog2(N) : 1;

   logic [KDIM_W-1:0] kw_c, kh_c;
   logic [2:0]        sw_c, sh_c;
   logic [DIM_W-1:0]  w_c, h_c, n_c;

   assign kw_c = KDIM_W'(clamp_dim(DIM_W'(cfg.kernel_w), DIM_W'(KERNEL_MAX)));
   assign kh_c = KDIM_W'(clamp_dim(DIM_W'(cfg.kernel_h), DIM_W'(KERNEL_MAX)));
   assign sw_c = 3'(clamp_dim(DIM_W'(cfg.stride_w), DIM_W'(7)));
   assign sh_c = 3'(clamp_dim(DIM_W'(cfg.stride_h), DIM_W'(7)));
   assign w_c  = clamp_dim(DIM_W'(cfg.image_width), DIM_W'(WIDTH_MAX));
   assign h_c  = clamp_dim(DIM_W'(cfg.image_height), DIM_W'(HEIGHT_MAX));
   assign n_c  = clamp_dim(DIM_W'(cfg.channel_count), DIM_W'(CHANNEL_MAX));

   logic pix;
   assign pix = in_valid && (in_func == FUNC_PIXEL);

   // raster counters
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CHW-1:0]    chan_ff, chan_in;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      chan_in = chan_ff;
      if (pix) begin
         if (DIM_W'(col_ff) + DIM_W'(1) >= w_c) begin
            col_in = '0;
            if (DIM_W'(row_ff) + DIM_W'(1) >= h_c) begin
               row_in  = '0;
               slot_in = '0;
               chan_in = (DIM_W'(chan_ff) + DIM_W'(1) >= n_c) ? '0 : chan_ff + 1'b1;
            end else begin
               row_in  = row_ff + 1'b1;
               slot_in = (slot_ff == SLOT_W'(LINES - 1)) ? '0 : slot_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
         chan_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
         chan_ff <= chan_in;
      end
   end

   // stage 1: line store word arrives
   logic                s1_pix_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [CW-1:0]       s1_col_ff;
   logic [RW-1:0]       s1_row_ff;
   logic [SLOT_W-1:0]   s1_slot_ff;
   logic                s1_chl_ff;
   logic                s1_fwd_ff;
   logic [LINES-1:0][SAMPLE_W-1:0] fwd_word_ff;
   logic [LINES-1:0][SAMPLE_W-1:0] rd_word, line_word, wr_word;

   dwc_ram #(.WIDTH(LINES * SAMPLE_W), .DEPTH(WIDTH_MAX)) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_pix_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wr_word),
      .rd_en   (pix),
      .rd_addr (col_ff),
      .rd_data (rd_word)
   );

   // the write at this edge is not yet visible to a read of the same column
   assign line_word = s1_fwd_ff ? fwd_word_ff : rd_word;

   always_comb begin
      for (int l = 0; l < LINES; l++) begin
         wr_word[l] = (SLOT_W'(l) == s1_slot_ff) ? s1_sample_ff : line_word[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_pix_ff <= 1'b0;
      else s1_pix_ff <= pix;
      s1_sample_ff <= in_sample;
      s1_col_ff    <= col_ff;
      s1_row_ff    <= row_ff;
      s1_slot_ff   <= slot_ff;
      s1_chl_ff    <= (DIM_W'(chan_ff) + DIM_W'(1) >= n_c);
      s1_fwd_ff    <= s1_pix_ff && (s1_col_ff == col_ff);
      fwd_word_ff  <= wr_word;
   end

   // new window column, newest row at the bottom
   logic [KERNEL_MAX-1:0][SAMPLE_W-1:0] col_new;
   always_comb begin
      int d;
      col_new[KERNEL_MAX-1] = s1_sample_ff;
      for (int m = 1; m < KERNEL_MAX; m++) begin
         d = int'(s1_slot_ff) - (((m % LINES) == 0) ? LINES : (m % LINES));
         if (d < 0) d = d + LINES;
         col_new[KERNEL_MAX-1-m] = line_word[SLOT_W'(d)];
      end
   end

   logic [KERNEL_MAX-1:0][KERNEL_MAX-1:0][SAMPLE_W-1:0] win_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_pix_ff) begin
         for (int m = 0; m < KERNEL_MAX; m++) begin
            for (int n = 0; n < KERNEL_MAX - 1; n++) win_ff[m][n] <= win_ff[m][n+1];
            win_ff[m][KERNEL_MAX-1] <= col_new[m];
         end
      end
   end

   // cells outside the kernel may hold never-written line store words
   always_comb begin
      for (int i = 0; i < KERNEL_MAX; i++)
         for (int j = 0; j < KERNEL_MAX; j++)
            win_o[i*KERNEL_MAX+j] = (i >= KERNEL_MAX - int'(kh_c) &&
                                     j >= KERNEL_MAX - int'(kw_c)) ? win_ff[i][j] : '0;
   end

   // weights and bias written at acceptance
   logic [N-1:0][SAMPLE_W-1:0] wt_ff;
   logic [SAMPLE_W-1:0]        bias_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         wt_ff   <= '0;
         bias_ff <= '0;
      end else if (in_valid) begin
         if (in_func == FUNC_WEIGHT && 8'(in_weight_index) < 8'(N))
            wt_ff[WI_W'(in_weight_index)] <= in_sample;
         if (in_func == FUNC_BIAS) bias_ff <= in_sample;
      end
   end

   // weight for every window cell under the current kernel size
   logic [N-1:0][SAMPLE_W-1:0] wsel_in;
   always_comb begin
      int mi, ni, ix;
      for (int i = 0; i < KERNEL_MAX; i++) begin
         for (int j = 0; j < KERNEL_MAX; j++) begin
            mi = i - (KERNEL_MAX - int'(kh_c));
            ni = j - (KERNEL_MAX - int'(kw_c));
            ix = mi * int'(kw_c) + ni;
            if (mi >= 0 && ni >= 0) wsel_in[i*KERNEL_MAX+j] = wt_ff[WI_W'(ix)];
            else wsel_in[i*KERNEL_MAX+j] = '0;
         end
      end
   end

   // window position test on the stride grid
   logic [DIM_W-1:0] c1, r1;
   logic [DIM_W-1:0] last_r_ff, last_c_ff;
   logic             hit;
   dwc_tag_type      tag_in;

   assign c1 = DIM_W'(s1_col_ff);
   assign r1 = DIM_W'(s1_row_ff);

   always_comb begin
      hit = s1_pix_ff && (c1 < w_c) && (r1 < h_c)
         && (r1 + DIM_W'(1) >= DIM_W'(kh_c)) && (c1 + DIM_W'(1) >= DIM_W'(kw_c))
         && (mod_small(r1 + DIM_W'(1) - DIM_W'(kh_c), sh_c) == 3'd0)
         && (mod_small(c1 + DIM_W'(1) - DIM_W'(kw_c), sw_c) == 3'd0);
      tag_in.res     = hit;
      tag_in.last_ch = (r1 == last_r_ff) && (c1 == last_c_ff);
      tag_in.last_fr = tag_in.last_ch && s1_chl_ff;
   end

   always_ff @(posedge clock) begin
      last_r_ff  <= h_c - DIM_W'(1) - DIM_W'(mod_small(h_c - DIM_W'(kh_c), sh_c));
      last_c_ff  <= w_c - DIM_W'(1) - DIM_W'(mod_small(w_c - DIM_W'(kw_c), sw_c));
      wsel_ff    <= wsel_in;
      bias_s2_ff <= bias_ff;
      if (reset) tag_s2_ff <= '0;
      else tag_s2_ff <= tag_in;
   end

   assign occ = {s1_pix_ff, tag_s2_ff.res};
endmodule
`default_nettype wire

/* rtl/dwc_mac.sv */
// Parallel multipliers, registered adder tree, bias, ReLU, rounding and saturation.
`default_nettype none
module dwc_mac import dwc_pkg::*; #(
   parameter int KERNEL_MAX = KERNEL_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        relu_enable,
   input  wire logic [KERNEL_MAX*KERNEL_MAX-1:0][SAMPLE_W-1:0] win_i,
   input  wire logic [KERNEL_MAX*KERNEL_MAX-1:0][SAMPLE_W-1:0] wsel_i,
   input  wire logic [SAMPLE_W-1:0] bias_i,
   input  wire dwc_tag_type tag_i,
   output dwc_tag_type      tag_o,
   output logic [SAMPLE_W-1:0] result_o,
   output logic [3:0]       occ
);
   localparam int N  = KERNEL_MAX * KERNEL_MAX;
   localparam int G1 = (N + 3) / 4;
   localparam int G2 = (G1 + 3) / 4;
   localparam int QW = ACC_W - 14;
   localparam logic signed [QW-1:0] Q_MAX = 32767;
   localparam logic signed [QW-1:0] Q_MIN = -32768;

   logic signed [31:0]      prod_ff [N];
   logic signed [ACC_W-1:0] sum1_ff [G1];
   logic signed [ACC_W-1:0] sum1_in [G1];
   logic signed [ACC_W-1:0] sum2_ff [G2];
   logic signed [ACC_W-1:0] sum2_in [G2];
   logic signed [ACC_W-1:0] total_ff, total_in;
   logic [SAMPLE_W-1:0]     bias3_ff, bias4_ff, bias5_ff;
   dwc_tag_type             tag3_ff, tag4_ff, tag5_ff, tag6_ff;

   always_ff @(posedge clock) begin
      for (int n = 0; n < N; n++) prod_ff[n] <= $signed(win_i[n]) * $signed(wsel_i[n]);
   end

   always_comb begin
      for (int g = 0; g < G1; g++) begin
         sum1_in[g] = '0;
         for (int t = 0; t < 4; t++)
            if (4 * g + t < N) sum1_in[g] = sum1_in[g] + ACC_W'(prod_ff[4*g+t]);
      end
      for (int g = 0; g < G2; g++) begin
         sum2_in[g] = '0;
         for (int t = 0; t < 4; t++)
            if (4 * g + t < G1) sum2_in[g] = sum2_in[g] + sum1_ff[4*g+t];
      end
      total_in = ACC_W'($signed(bias5_ff)) <<< 14;
      for (int g = 0; g < G2; g++) total_in = total_in + sum2_ff[g];
   end

   always_ff @(posedge clock) begin
      sum1_ff  <= sum1_in;
      sum2_ff  <= sum2_in;
      total_ff <= total_in;
      bias3_ff <= bias_i;
      bias4_ff <= bias3_ff;
      bias5_ff <= bias4_ff;
      if (reset) begin
         tag3_ff <= '0;
         tag4_ff <= '0;
         tag5_ff <= '0;
         tag6_ff <= '0;
      end else begin
         tag3_ff <= tag_i;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
         tag6_ff <= tag5_ff;
      end
   end

   // round half up back to the sample scale via arithmetic shift (weights as Q2.14), then saturate
   logic signed [ACC_W-1:0] relu_v, rnd;
   logic signed [QW-1:0]    q;
   always_comb begin
      relu_v = (relu_enable && total_ff < 0) ? '0 : total_ff;
      rnd    = relu_v + $signed(ACC_W'(8192));
      q      = rnd[ACC_W-1:14];
      if (q > Q_MAX) result_o = 16'h7FFF;
      else if (q < Q_MIN) result_o = 16'h8000;
      else result_o = q[SAMPLE_W-1:0];
   end

   assign tag_o = tag6_ff;
   assign occ   = {tag3_ff.res, tag4_ff.res, tag5_ff.res, tag6_ff.res};
endmodule
`default_nettype wire

/* rtl/depthwise_conv2d_stream.sv */
// Top level of the streaming depthwise 2-D convolution block.
//
// Usage:
//  - req channel: tuser carries the item kind (pixel, weight load, bias load),
//    tdata the sample and the weight index. Load a channel's weights and bias,
//    then stream its pixels in raster order; channels follow each other.
//  - rsp channel: one transaction per window position on the stride grid;
//    tlast marks the last result of a channel, tuser the last of the frame.
//  - csr port: write enable, register index, data; write only while idle.
//  - Throughput: one item per cycle while req_tready is high, set by the line
//    store read-modify-write of one column per cycle and the window shift.
//  - Result path: line store, window and tag, product, tree sums, total, FIFO.
//  - A result FIFO of 8 entries decouples the sides; when rsp stalls, req
//    keeps accepting until FIFO entries, pending results and a pixel in the
//    line store stage reach 8.
//  - Reset clears counters, window, weights, bias and registers to defaults;
//    the line store needs no clearing pass.
`default_nettype none
`include "depthwise_conv2d_stream_defines.svh"
module depthwise_conv2d_stream import dwc_pkg::*; #(
   parameter int KERNEL_MAX  = KERNEL_MAX_DEF,
   parameter int WIDTH_MAX   = WIDTH_MAX_DEF,
   parameter int HEIGHT_MAX  = HEIGHT_MAX_DEF,
   parameter int CHANNEL_MAX = CHANNEL_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // sample_value[15:0], weight_index[21:16]
   input  wire logic [1:0]  req_tuser,   // func[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // result_value[15:0]
   output logic             rsp_tlast,
   output logic [0:0]       rsp_tuser,   // last_in_frame[0]
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int N = KERNEL_MAX * KERNEL_MAX;

   dwc_cfg_type cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.relu_enable   <= 1'b0;
         cfg_ff.kernel_w      <= 3'd3;
         cfg_ff.kernel_h      <= 3'd3;
         cfg_ff.stride_w      <= 3'd1;
         cfg_ff.stride_h      <= 3'd1;
         cfg_ff.image_width   <= 9'd16;
         cfg_ff.image_height  <= 9'd16;
         cfg_ff.channel_count <= 11'd1;
      end else if (csr_we) begin
         case (dwc_reg_type'(csr_index))
            REG_RELU:     cfg_ff.relu_enable   <= csr_wdata[0];
            REG_KERNEL_W: cfg_ff.kernel_w      <= csr_wdata[2:0];
            REG_KERNEL_H: cfg_ff.kernel_h      <= csr_wdata[2:0];
            REG_STRIDE_W: cfg_ff.stride_w      <= csr_wdata[2:0];
            REG_STRIDE_H: cfg_ff.stride_h      <= csr_wdata[2:0];
            REG_IMAGE_W:  cfg_ff.image_width   <= csr_wdata[8:0];
            REG_IMAGE_H:  cfg_ff.image_height  <= csr_wdata[8:0];
            REG_CHANNELS: cfg_ff.channel_count <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   logic [N-1:0][SAMPLE_W-1:0] win, wsel;
   logic [SAMPLE_W-1:0]        bias_s2;
   dwc_tag_type                tag_s2, tag_out;
   logic [SAMPLE_W-1:0]        result;
   logic [1:0]                 front_occ;
   logic [3:0]                 mac_occ;

   dwc_front #(
      .KERNEL_MAX (KERNEL_MAX),
      .WIDTH_MAX  (WIDTH_MAX),
      .HEIGHT_MAX (HEIGHT_MAX),
      .CHANNEL_MAX(CHANNEL_MAX)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (req_fire),
      .in_func        (dwc_func_type'(req_tuser)),
      .in_sample      (req_tdata[15:0]),
      .in_weight_index(req_tdata[21:16]),
      .win_o          (win),
      .wsel_ff        (wsel),
      .bias_s2_ff     (bias_s2),
      .tag_s2_ff      (tag_s2),
      .occ            (front_occ)
   );

   dwc_mac #(.KERNEL_MAX(KERNEL_MAX)) u_mac (
      .clock      (clock),
      .reset      (reset),
      .relu_enable(cfg_ff.relu_enable),
      .win_i      (win),
      .wsel_i     (wsel),
      .bias_i     (bias_s2),
      .tag_i      (tag_s2),
      .tag_o      (tag_out),
      .result_o   (result),
      .occ        (mac_occ)
   );

   // result FIFO with credit over the pipeline
   logic [17:0]        fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]   fifo_cnt_ff;
   logic [2:0]         inflight;
   logic               fifo_push, rsp_pop;

   assign inflight  = 3'($countones({front_occ, mac_occ}));
   assign fifo_push = tag_out.res;
   assign rsp_pop   = rsp_tvalid && rsp_tready;
   assign req_tready = (5'(inflight) + 5'(fifo_cnt_ff)) < 5'(FIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (fifo_push) fifo_ff[wr_ptr_ff] <= {tag_out.last_fr, tag_out.last_ch, result};
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (fifo_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rsp_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         fifo_cnt_ff <= fifo_cnt_ff + (FIFO_AW+1)'(fifo_push) - (FIFO_AW+1)'(rsp_pop);
      end
   end

   assign rsp_tvalid   = (fifo_cnt_ff != '0);
   assign rsp_tdata    = fifo_ff[rd_ptr_ff][15:0];
   assign rsp_tlast    = fifo_ff[rd_ptr_ff][16];
   assign rsp_tuser[0] = fifo_ff[rd_ptr_ff][17];

   `DWC_ASSERT_IMP(a_no_overflow, clock, reset, fifo_push, fifo_cnt_ff != (FIFO_AW+1)'(FIFO_DEPTH))
   `DWC_ASSERT_IMP(a_credit, clock, reset, 1'b1, (5'(inflight) + 5'(fifo_cnt_ff)) <= 5'(FIFO_DEPTH))
   `DWC_ASSERT_NEXT(a_pop_count, clock, reset, rsp_pop && !fifo_push, fifo_cnt_ff == $past(fifo_cnt_ff) - 1'b1)
endmodule
`default_nettype wire

/* test/tb_depthwise_conv2d_stream.sv */
// Self-checking stream testbench for the depthwise 2-D convolution block.
`timescale 1ns / 100ps
`default_nettype none
module tb_depthwise_conv2d_stream;
   import dwc_pkg::*;

   localparam int KMAX     = 7;
   localparam int WMAX     = 256;
   localparam int HMAX     = 256;
   localparam int CMAX     = 1024;
   localparam int LINES    = 6;
   localparam int WD_LIMIT = 5000;
   localparam int SETTLE   = 20;

   typedef struct {
      dwc_func_type func;
      logic [15:0]  sample;
      logic [5:0]   widx;
   } conv_item_t;

   typedef struct {
      logic [15:0] value;
      logic        last_ch;
      logic        last_fr;
   } conv_out_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   depthwise_conv2d_stream u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the block's registers and state
   int unsigned cfg_relu, cfg_kw, cfg_kh, cfg_sw, cfg_sh, cfg_w, cfg_h, cfg_nch;
   logic signed [15:0] line_mem [0:LINES*WMAX-1];
   logic signed [15:0] win [0:KMAX-1][0:KMAX-1];
   logic signed [15:0] wts [0:KMAX*KMAX-1];
   logic signed [15:0] bias;
   int unsigned col_cnt, row_cnt, chan_idx;

   conv_item_t pending[$];
   conv_out_t  conv_expected[$];
   conv_item_t cur_item;
   int         mismatches = 0;
   bit         idle_en = 1'b1;
   int         quiet_cycles = 0;
   int         items_sent = 0;

   function automatic int unsigned clampu(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void shadow_reset();
      cfg_relu = 0; cfg_kw = 3; cfg_kh = 3; cfg_sw = 1; cfg_sh = 1;
      cfg_w = 16; cfg_h = 16; cfg_nch = 1;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      foreach (wts[i]) wts[i] = '0;
      bias = '0;
      col_cnt = 0; row_cnt = 0; chan_idx = 0;
   endfunction

   function automatic void shadow_write(dwc_reg_type idx, int unsigned v);
      case (idx)
         REG_RELU:     cfg_relu = v & 1;
         REG_KERNEL_W: cfg_kw = v & 7;
         REG_KERNEL_H: cfg_kh = v & 7;
         REG_STRIDE_W: cfg_sw = v & 7;
         REG_STRIDE_H: cfg_sh = v & 7;
         REG_IMAGE_W:  cfg_w = v & 'h1ff;
         REG_IMAGE_H:  cfg_h = v & 'h1ff;
         REG_CHANNELS: cfg_nch = v & 'h7ff;
         default: ;
      endcase
   endfunction

   // advance the shadow by one item and queue the output it yields
   function automatic void conv_predict(conv_item_t it);
      int unsigned kw, kh, sw, sh, w, h, nch, c, r, slot, s, lastr, lastc;
      longint acc, q;
      conv_out_t o;
      bit lc;
      if (it.func == FUNC_WEIGHT) begin
         if (it.widx < KMAX*KMAX) wts[it.widx] = it.sample;
         return;
      end
      if (it.func == FUNC_BIAS) begin
         bias = it.sample;
         return;
      end
      if (it.func != FUNC_PIXEL) return;
      kw = clampu(cfg_kw, KMAX); kh = clampu(cfg_kh, KMAX);
      sw = clampu(cfg_sw, 7);    sh = clampu(cfg_sh, 7);
      w = clampu(cfg_w, WMAX);   h = clampu(cfg_h, HMAX);
      nch = clampu(cfg_nch, CMAX);
      c = col_cnt; r = row_cnt; slot = r % LINES;
      for (int m = 0; m < KMAX; m++)
         for (int n = 0; n < KMAX-1; n++) win[m][n] = win[m][n+1];
      win[KMAX-1][KMAX-1] = it.sample;
      for (int m = 1; m < KMAX; m++) begin
         s = (slot + LINES - ((m % LINES == 0) ? LINES : m % LINES)) % LINES;
         win[KMAX-1-m][KMAX-1] = line_mem[s*WMAX + c];
      end
      line_mem[slot*WMAX + c] = it.sample;
      if (c < w && r < h && r + 1 >= kh && c + 1 >= kw &&
          (r + 1 - kh) % sh == 0 && (c + 1 - kw) % sw == 0) begin
         acc = longint'(bias) * 16384;
         for (int m = 0; m < kh; m++)
            for (int n = 0; n < kw; n++)
               acc += longint'(win[KMAX-kh+m][KMAX-kw+n]) * longint'(wts[m*kw+n]);
         if (cfg_relu != 0 && acc < 0) acc = 0;
         q = (acc + 8192) >>> 14;   // floor, so halves round up
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         lastr = (kh - 1) + ((h - kh) / sh) * sh;
         lastc = (kw - 1) + ((w - kw) / sw) * sw;
         lc = (r == lastr) && (c == lastc);
         o.value = q[15:0];
         o.last_ch = lc;
         o.last_fr = lc && (chan_idx + 1 >= nch);
         conv_expected.push_back(o);
      end
      if (c + 1 >= w) begin
         col_cnt = 0;
         if (r + 1 >= h) begin
            row_cnt = 0;
            chan_idx = (chan_idx + 1 >= nch) ? 0 : chan_idx + 1;
         end else row_cnt = r + 1;
      end else col_cnt = c + 1;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] exp_v);
      $display("ERROR t=%0t %s: got %h expected %h", $realtime, what, got, exp_v);
      mismatches++;
   endtask

   // req side driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) conv_predict(cur_item);
         if (!req_tvalid || req_tready) begin
            if (pending.size() > 0 && !(idle_en && $urandom_range(0, 99) < 12)) begin
               cur_item = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {2'b00, cur_item.widx, cur_item.sample};
               req_tuser <= cur_item.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // rsp side monitor, stall generator and watchdog
   always @(posedge clock) begin
      conv_out_t e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_en && $urandom_range(0, 99) < 12);
         if (rsp_tvalid && rsp_tready) begin
            if (conv_expected.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_tdata, 16'h0);
            end else begin
               e = conv_expected.pop_front();
               if (rsp_tdata !== e.value) report_mismatch("result_value", rsp_tdata, e.value);
               if (rsp_tlast !== e.last_ch)
                  report_mismatch("last_in_channel", 16'(rsp_tlast), 16'(e.last_ch));
               if (rsp_tuser[0] !== e.last_fr)
                  report_mismatch("last_in_frame", 16'(rsp_tuser[0]), 16'(e.last_fr));
            end
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WD_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic set_reg(dwc_reg_type idx, int unsigned v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[CSR_DATA_W-1:0];
      shadow_write(idx, v);
   endtask

   task automatic set_geometry(int unsigned relu, kw, kh, sw, sh, w, h, nch);
      set_reg(REG_RELU, relu);
      set_reg(REG_KERNEL_W, kw);
      set_reg(REG_KERNEL_H, kh);
      set_reg(REG_STRIDE_W, sw);
      set_reg(REG_STRIDE_H, sh);
      set_reg(REG_IMAGE_W, w);
      set_reg(REG_IMAGE_H, h);
      set_reg(REG_CHANNELS, nch);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // block goes idle: nothing queued, in flight or outstanding
   task automatic wait_drained();
      while (pending.size() != 0 || req_tvalid || conv_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic push_item(dwc_func_type f, int unsigned s, int unsigned wi);
      conv_item_t it;
      it.func = f;
      it.sample = s[15:0];
      it.widx = wi[5:0];
      pending.push_back(it);
      items_sent++;
   endtask

   function automatic int unsigned rand_value();
      int unsigned v;
      if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 65535);
      else v = 16'($signed($urandom_range(0, 2047)) - 1024);
      return v;
   endfunction

   initial begin
      int unsigned kw, kh, sw, sh, w, h, nch, n_ch, cnt, npix;
      dwc_func_type noise_f;
      shadow_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, saturation, ignored items, relu
      set_geometry(1, 2, 2, 1, 1, 3, 2, 1);
      push_item(FUNC_WEIGHT, 16'h7fff, 0);
      push_item(FUNC_WEIGHT, 16'h8000, 1);
      push_item(FUNC_WEIGHT, 16'h7fff, 2);
      push_item(FUNC_WEIGHT, 16'h7fff, 3);
      push_item(FUNC_WEIGHT, 16'h1234, 63);   // out of range index
      push_item(FUNC_BIAS, 16'h7fff, 0);
      noise_f = dwc_func_type'(2'd3);
      push_item(noise_f, 16'hffff, 6'h2a);
      push_item(FUNC_PIXEL, 16'h7fff, 0);
      push_item(FUNC_PIXEL, 16'h8000, 0);
      push_item(FUNC_PIXEL, 16'h7fff, 0);
      push_item(FUNC_PIXEL, 16'h8000, 0);
      push_item(FUNC_BIAS, 16'h8000, 0);
      push_item(FUNC_PIXEL, 16'h8000, 0);
      push_item(FUNC_PIXEL, 16'h7fff, 0);
      wait_drained();
      set_geometry(0, 1, 1, 7, 7, 2, 2, 2047);
      push_item(FUNC_WEIGHT, 16'h4000, 0);
      push_item(FUNC_BIAS, 16'h0080, 0);
      for (int i = 0; i < 4; i++) push_item(FUNC_PIXEL, 16'h8000 + i, 0);
      push_item(FUNC_WEIGHT, 16'hc001, 0);
      push_item(FUNC_PIXEL, 16'h0001, 0);
      push_item(FUNC_PIXEL, 16'hffff, 0);
      push_item(FUNC_PIXEL, 16'h0100, 0);
      push_item(FUNC_PIXEL, 16'h0200, 0);
      wait_drained();

      // one row of the widest image, stride four
      set_geometry(0, 7, 1, 4, 0, 511, 1, 1);
      for (int i = 0; i < 7; i++) push_item(FUNC_WEIGHT, rand_value(), i);
      for (int i = 0; i < WMAX; i++) push_item(FUNC_PIXEL, rand_value(), 0);
      wait_drained();

      // random phases of whole channels with occasional noise
      cnt = 0;
      while (items_sent < 1050) begin
         kw = $urandom_range(1, 7);
         kh = $urandom_range(1, 7);
         sw = $urandom_range(1, 4);
         sh = $urandom_range(1, 4);
         w = kw + $urandom_range(0, 8);
         h = kh + $urandom_range(0, 4);
         if ($urandom_range(0, 9) == 0) begin
            w = $urandom_range(1, 4);
            kw = $urandom_range(0, 7);
            sw = $urandom_range(0, 7);
         end
         nch = $urandom_range(1, 3);
         n_ch = $urandom_range(1, 2);
         idle_en = (cnt % 8 != 3);   // some phases run back to back
         set_geometry($urandom_range(0, 1), kw, kh, sw, sh, w, h, nch);
         for (int ch = 0; ch < n_ch; ch++) begin
            for (int i = 0; i < KMAX*KMAX; i++)
               if (i < clampu(kw, KMAX) * clampu(kh, KMAX) || $urandom_range(0, 15) == 0)
                  push_item(FUNC_WEIGHT, rand_value(), i);
            push_item(FUNC_BIAS, rand_value(), $urandom_range(0, 63));
            npix = clampu(w, WMAX) * h;
            for (int p = 0; p < npix; p++) begin
               if ($urandom_range(0, 31) == 0)
                  push_item(dwc_func_type'(2'd3), $urandom_range(0, 65535),
                            $urandom_range(0, 63));
               if ($urandom_range(0, 31) == 0)
                  push_item(FUNC_WEIGHT, rand_value(), $urandom_range(0, 63));
               push_item(FUNC_PIXEL, rand_value(), $urandom_range(0, 63));
            end
         end
         cnt++;
         wait_drained();
      end
      idle_en = 1'b1;
      wait_drained();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/dwc_pkg.sv
rtl/dwc_ram.sv
rtl/dwc_front.sv
rtl/dwc_mac.sv
rtl/depthwise_conv2d_stream.sv
test/tb_depthwise_conv2d_stream.sv
